[hw/rtl/i2cm_pkg.sv]
// i2cm_pkg: shared types and constants for the i2c master byte engine
// no dependencies; used by the interfaces, the timer, the top level and the checker
package i2cm_pkg;

  // width of the half period register
  localparam int HP_W = 16;

  // command codes carried in the op field
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_START   = 3'd1;
  localparam logic [2:0] OP_STOP    = 3'd2;
  localparam logic [2:0] OP_WRITE   = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;
  localparam logic [2:0] OP_RECOVER = 3'd5;

  localparam logic [HP_W-1:0] HALF_PERIOD_RESET = 16'd100;
  localparam logic [3:0]      BITS_PER_BYTE     = 4'd8;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] write_data;
    logic       send_ack;
    logic       scl_in;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       done_res;
    logic [7:0] read_byte;
    logic       acked;
    logic       fault;
    logic       busy_res;
    logic       rejected;
  } out_item_t;

  // phase timer controls, highest priority first: load, clear, dec
  typedef struct packed {
    logic load;
    logic clear;
    logic dec;
  } tmr_ctl_t;

endpackage

[hw/rtl/i2cm_if.sv]
// i2cm_if: valid/ready channels for the tick items and the result items
// depends on i2cm_pkg
interface i2cm_in_if;
  logic              valid;
  logic              ready;
  i2cm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2cm_out_if;
  logic               valid;
  logic               ready;
  i2cm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/i2cm_timer.sv]
// i2cm_timer: line phase hold counter, reloaded with half_period - 1
// depends on i2cm_pkg
module i2cm_timer #(
  parameter int DELAY_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [i2cm_pkg::HP_W-1:0]  half_period,
  input  i2cm_pkg::tmr_ctl_t         ctl,
  output logic                       expired
);
  import i2cm_pkg::*;

  logic [DELAY_BITS-1:0] count;
  logic [HP_W-1:0]       reload;

  // zero half period acts as one
  assign reload  = (half_period == '0) ? '0 : half_period - HP_W'(1);
  assign expired = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.load) begin
      count <= DELAY_BITS'(reload);
    end else if (ctl.clear) begin
      count <= '0;
    end else if (ctl.dec) begin
      count <= count - DELAY_BITS'(1);
    end
  end

endmodule

[hw/rtl/i2c_master_byte_engine.sv]
// i2c_master_byte_engine: open-drain i2c master, one clock tick per transaction
// depends on i2cm_pkg, i2cm_if and i2cm_timer
//
//  channel   dir  payload                                          handshake
//  in_ch     in   op, write_data, send_ack, scl_in, sda_in         valid/ready
//  out_ch    out  scl_low, sda_low, done_res, read_byte, acked,    valid/ready
//                 fault, busy_res, rejected
//  cfg       in   cfg_wdata = half_period                          cfg_we
//
//  every tick transaction yields one result transaction, registered on acceptance
//  one tick is accepted per clock while the result register is free; the next state is one pass of logic from the
//  state registers into the result register
//  in_ch.ready drops only while a result is held and out_ch.ready is low
//  synchronous reset: idle, lines released, half_period 100, no result pending
//  line phases are counted in ticks, not clocks, so stalls stretch the bus timing
module i2c_master_byte_engine #(
  parameter int RECOVERY_PULSES = 32,
  parameter int DELAY_BITS      = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  i2cm_in_if.sink                    in_ch,
  i2cm_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [i2cm_pkg::HP_W-1:0]  cfg_wdata
);
  import i2cm_pkg::*;

  // pulse counter only needs to reach the configured pulse limit
  localparam int PULSE_W = $clog2(RECOVERY_PULSES + 1);

  // s = start, p = stop, w = write, r = read, c = recovery
  typedef enum logic [4:0] {
    PH_IDLE,
    PH_S1, PH_S2, PH_S3, PH_S4,
    PH_P1, PH_P2, PH_P3,
    PH_W1, PH_W2, PH_W3, PH_W4, PH_W4B, PH_W5, PH_W6,
    PH_R1, PH_R2, PH_R3, PH_R4, PH_R5, PH_R6, PH_R7,
    PH_C1, PH_C2, PH_C3, PH_C4, PH_C5,
    PH_FIN
  } phase_t;

  // sequencer state
  phase_t             phase;
  logic [3:0]         bit_count;
  logic [7:0]         shift_reg;
  logic [PULSE_W-1:0] pulse_count;
  logic               ack_to_send;
  logic               ack_seen;
  logic               fault_flag;
  logic               scl_drive;
  logic               sda_drive;
  logic [7:0]         last_read;
  logic [HP_W-1:0]    half_period;

  // state after command decode, before the phase action
  phase_t     phase_e;
  logic [3:0] bit_count_e;
  logic [7:0] shift_e;
  logic       ack_to_send_e;

  // next state
  phase_t             phase_next;
  logic [3:0]         bit_count_next;
  logic [7:0]         shift_next;
  logic [PULSE_W-1:0] pulse_next;
  logic               ack_to_send_next;
  logic               ack_seen_next;
  logic               fault_next;
  logic               scl_next;
  logic               sda_next;
  logic [7:0]         last_read_next;

  logic       accept;
  logic       cmd_ok;
  logic       start;
  logic       rejected;
  logic       act;
  logic       expired;
  logic       do_hold;
  logic       do_tick;
  logic       done;
  logic [3:0] bit_inc;
  logic [PULSE_W-1:0] pulse_inc;
  tmr_ctl_t   tmr_ctl;
  in_item_t   item;
  out_item_t  result;

  assign item   = in_ch.data;
  // result register frees up when empty or being drained
  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;

  // unknown op codes are dropped silently while idle
  assign cmd_ok   = (item.op == OP_START) || (item.op == OP_STOP) || (item.op == OP_WRITE)
                 || (item.op == OP_READ)  || (item.op == OP_RECOVER);
  assign rejected = (item.op != OP_NONE) && (phase != PH_IDLE);
  assign start    = (phase == PH_IDLE) && cmd_ok;

  always_comb begin
    phase_e       = phase;
    bit_count_e   = bit_count;
    shift_e       = shift_reg;
    ack_to_send_e = ack_to_send;
    if (start) begin
      bit_count_e = '0;
      unique case (item.op)
        OP_START: phase_e = PH_S1;
        OP_STOP:  phase_e = PH_P1;
        OP_WRITE: begin
          phase_e = PH_W1;
          shift_e = item.write_data;
        end
        OP_READ: begin
          phase_e       = PH_R1;
          shift_e       = '0;
          ack_to_send_e = item.send_ack;
        end
        default:  phase_e = PH_C1;
      endcase
    end
  end

  // a fresh command always acts on its first tick
  assign act       = (phase_e != PH_IDLE) && (start || expired);
  assign bit_inc   = bit_count_e + 4'd1;
  assign pulse_inc = pulse_count + PULSE_W'(1);

  // phase actions
  always_comb begin
    phase_next       = phase_e;
    bit_count_next   = bit_count_e;
    shift_next       = shift_e;
    pulse_next       = pulse_count;
    ack_to_send_next = ack_to_send_e;
    ack_seen_next    = ack_seen;
    fault_next       = fault_flag;
    scl_next         = scl_drive;
    sda_next         = sda_drive;
    last_read_next   = last_read;
    do_hold          = 1'b0;
    do_tick          = 1'b0;
    done             = 1'b0;
    if (act) begin
      unique case (phase_e)
        PH_S1: begin sda_next = 1'b0; do_hold = 1'b1; phase_next = PH_S2; end
        PH_S2: begin scl_next = 1'b0; do_hold = 1'b1; phase_next = PH_S3; end
        PH_S3: begin sda_next = 1'b1; do_hold = 1'b1; phase_next = PH_S4; end
        PH_S4: begin scl_next = 1'b1; do_hold = 1'b1; phase_next = PH_FIN; end
        PH_P1: begin sda_next = 1'b1; do_hold = 1'b1; phase_next = PH_P2; end
        PH_P2: begin scl_next = 1'b0; do_hold = 1'b1; phase_next = PH_P3; end
        PH_P3: begin sda_next = 1'b0; do_hold = 1'b1; phase_next = PH_FIN; end
        PH_W1: begin
          // msb first, a one releases sda
          sda_next   = !shift_e[7];
          shift_next = {shift_e[6:0], 1'b0};
          do_hold    = 1'b1;
          phase_next = PH_W2;
        end
        PH_W2: begin scl_next = 1'b0; do_hold = 1'b1; phase_next = PH_W3; end
        PH_W3: begin
          scl_next       = 1'b1;
          bit_count_next = bit_inc;
          do_tick        = 1'b1;
          phase_next     = (bit_inc >= BITS_PER_BYTE) ? PH_W4 : PH_W1;
        end
        PH_W4:  begin sda_next = 1'b0; do_hold = 1'b1; phase_next = PH_W4B; end
        PH_W4B: begin do_hold = 1'b1; phase_next = PH_W5; end
        PH_W5: begin
          ack_seen_next = !item.sda_in;
          scl_next      = 1'b0;
          do_hold       = 1'b1;
          phase_next    = PH_W6;
        end
        PH_W6: begin scl_next = 1'b1; do_hold = 1'b1; phase_next = PH_FIN; end
        PH_R1: begin sda_next = 1'b0; do_tick = 1'b1; phase_next = PH_R2; end
        PH_R2: begin scl_next = 1'b0; do_hold = 1'b1; phase_next = PH_R3; end
        PH_R3: begin
          if (!item.scl_in) begin
            // slave stretching the clock
            do_tick = 1'b1;
          end else begin
            shift_next     = {shift_e[6:0], item.sda_in};
            scl_next       = 1'b1;
            bit_count_next = bit_inc;
            do_hold        = 1'b1;
            phase_next     = (bit_inc >= BITS_PER_BYTE) ? PH_R4 : PH_R2;
          end
        end
        PH_R4: begin sda_next = ack_to_send_e; do_tick = 1'b1; phase_next = PH_R5; end
        PH_R5: begin scl_next = 1'b0; do_hold = 1'b1; phase_next = PH_R6; end
        PH_R6: begin scl_next = 1'b1; do_hold = 1'b1; phase_next = PH_R7; end
        PH_R7: begin
          sda_next       = 1'b0;
          last_read_next = shift_e;
          phase_next     = PH_IDLE;
          done           = 1'b1;
        end
        PH_C1: begin
          scl_next   = 1'b0;
          sda_next   = 1'b0;
          do_hold    = 1'b1;
          phase_next = PH_C2;
        end
        PH_C2: begin
          fault_next = !item.scl_in;
          if (item.sda_in) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end else begin
            pulse_next = '0;
            do_tick    = 1'b1;
            phase_next = PH_C3;
          end
        end
        PH_C3: begin scl_next = 1'b1; do_hold = 1'b1; phase_next = PH_C4; end
        PH_C4: begin scl_next = 1'b0; do_hold = 1'b1; phase_next = PH_C5; end
        PH_C5: begin
          pulse_next = pulse_inc;
          if (item.sda_in) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end else if (pulse_inc >= PULSE_W'(RECOVERY_PULSES)) begin
            // sda still stuck after the last pulse
            fault_next = 1'b1;
            phase_next = PH_IDLE;
            done       = 1'b1;
          end else begin
            do_tick    = 1'b1;
            phase_next = PH_C3;
          end
        end
        PH_FIN: begin phase_next = PH_IDLE; done = 1'b1; end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // hold timer: count down between actions, reload after a held action
  assign tmr_ctl.load  = accept && act && do_hold;
  assign tmr_ctl.clear = accept && (start || (act && do_tick));
  assign tmr_ctl.dec   = accept && (phase_e != PH_IDLE) && !act;

  i2cm_timer #(
    .DELAY_BITS (DELAY_BITS)
  ) u_timer (
    .clk         (clk),
    .rst         (rst),
    .half_period (half_period),
    .ctl         (tmr_ctl),
    .expired     (expired)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RESET;
    end else if (cfg_we) begin
      half_period <= cfg_wdata;
    end
  end

  // sequencer state, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= '0;
      shift_reg   <= '0;
      pulse_count <= '0;
      ack_to_send <= 1'b0;
      ack_seen    <= 1'b0;
      fault_flag  <= 1'b0;
      scl_drive   <= 1'b0;
      sda_drive   <= 1'b0;
      last_read   <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      shift_reg   <= shift_next;
      pulse_count <= pulse_next;
      ack_to_send <= ack_to_send_next;
      ack_seen    <= ack_seen_next;
      fault_flag  <= fault_next;
      scl_drive   <= scl_next;
      sda_drive   <= sda_next;
      last_read   <= last_read_next;
    end
  end

  // result as seen after this tick
  always_comb begin
    result.scl_low   = scl_next;
    result.sda_low   = sda_next;
    result.done_res  = done;
    result.read_byte = last_read_next;
    result.acked     = ack_seen_next;
    result.fault     = fault_next;
    result.busy_res  = (phase_next != PH_IDLE);
    result.rejected  = rejected;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (accept) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.data <= result;
    end
  end

endmodule

[hw/rtl/i2cm_checker.sv]
// i2cm_checker: port level assertions for the i2c master byte engine
// depends on i2cm_pkg; bound to i2c_master_byte_engine below
module i2cm_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input i2cm_pkg::out_item_t out_data
);
  import i2cm_pkg::*;

  // a finished command always leaves the engine idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done with busy still set");

  // a stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // the read byte only moves when a read completes
  a_read_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && $past(out_valid) && (out_data.read_byte != $past(out_data.read_byte))
      |-> out_data.done_res)
    else $error("read byte changed without completion");

  // lines stay put while the engine sits idle
  a_idle_lines: assert property (@(posedge clk) disable iff (rst)
    out_valid && $past(out_valid) && !$past(out_data.busy_res)
      && !out_data.busy_res && !out_data.done_res
      |-> (out_data.scl_low == $past(out_data.scl_low))
       && (out_data.sda_low == $past(out_data.sda_low)))
    else $error("line moved while idle");

endmodule

bind i2c_master_byte_engine i2cm_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
